/* rtl/rhcm_pkg.sv */
// Package with shared types and constants for the RGB to HSL color match block.
`timescale 1ns / 1ps
package rhcm_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned SumW = 9;
  localparam int unsigned QuoW = 17;
  localparam logic [ChanW-1:0] FullScale = 8'd240;
  localparam logic [ChanW-1:0] HalfScale = 8'd120;

  localparam logic [2:0] CfgHueLow  = 3'd0;
  localparam logic [2:0] CfgHueHigh = 3'd1;
  localparam logic [2:0] CfgSatLow  = 3'd2;
  localparam logic [2:0] CfgSatHigh = 3'd3;
  localparam logic [2:0] CfgLumLow  = 3'd4;
  localparam logic [2:0] CfgLumHigh = 3'd5;

  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  // Classified pixel passed from the front part to the back part.
  typedef struct packed {
    logic             grey;
    sector_e          sector;
    logic             neg;
    logic             wrap;
    logic [ChanW-1:0] hue_num;
    logic [ChanW-1:0] dif;
    logic [SumW-1:0]  sat_den;
    logic             sat_zero;
    logic [ChanW-1:0] lum;
  } cls_t;

  typedef struct packed {
    logic [ChanW-1:0] hue_low;
    logic [ChanW-1:0] hue_high;
    logic [ChanW-1:0] sat_low;
    logic [ChanW-1:0] sat_high;
    logic [ChanW-1:0] lum_low;
    logic [ChanW-1:0] lum_high;
  } win_t;

endpackage

/* rtl/rhcm_front.sv */
// Front part: accepts pixels, finds max, min, sector and luminance.
`timescale 1ns / 1ps
module rhcm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  output logic                 cls_valid_o,
  input  logic                 cls_ready_i,
  output rhcm_pkg::cls_t       cls_o
);
  import rhcm_pkg::*;

  logic [ChanW-1:0] mx, mn, dif, a, b;
  logic [SumW-1:0]  sum;
  logic [24:0]      lum_prod;
  logic [ChanW-1:0] lum;
  sector_e          sec;
  logic             valid_q;
  cls_t             cls_q, cls_d;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dif = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    // sum*240/255/2 equals floor(sum*8/17) for sum in 0..510.
    lum_prod = {13'd0, sum, 3'd0} * 25'd7711;
    lum = lum_prod[ChanW+16:17];
    if (mx == red_i) begin
      sec = SecRed;
      a = green_i;
      b = blue_i;
    end else if (mx == green_i) begin
      sec = SecGreen;
      a = blue_i;
      b = red_i;
    end else begin
      sec = SecBlue;
      a = red_i;
      b = green_i;
    end
    cls_d.grey = (dif == '0);
    cls_d.sector = sec;
    cls_d.neg = (a < b);
    cls_d.wrap = (sec == SecRed) && (a < b);
    cls_d.hue_num = (a < b) ? (b - a) : (a - b);
    cls_d.dif = dif;
    cls_d.sat_den = (lum <= HalfScale) ? sum : (9'd511 - sum);
    cls_d.sat_zero = (lum == '0);
    cls_d.lum = lum;
  end

  assign in_ready = !valid_q || cls_ready_i;
  assign cls_valid_o = valid_q;
  assign cls_o = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid) begin
      cls_q <= cls_d;
    end
  end

endmodule

/* rtl/rhcm_fifo.sv */
// Short queue between the front and back parts.
`timescale 1ns / 1ps
module rhcm_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  rhcm_pkg::cls_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output rhcm_pkg::cls_t rd_data_o
);
  import rhcm_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cls_t              mem_q [Depth];
  logic [AW-1:0]     wp_q, rp_q;
  logic [AW:0]       cnt_q;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != Depth[AW:0]);
  assign rd_valid_o = (cnt_q != '0);
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Depth[AW:0])
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

/* rtl/rhcm_back.sv */
// Back part: hue and saturation divisions and window match, pipelined.
`timescale 1ns / 1ps
module rhcm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cls_valid_i,
  output logic           cls_ready_o,
  input  rhcm_pkg::cls_t cls_i,
  input  rhcm_pkg::win_t win_i,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     hue_o,
  output logic [7:0]     saturation_o,
  output logic [7:0]     luminance_o,
  output logic           match_o
);
  import rhcm_pkg::*;

  // Stage 1: numerators. Stages 2..9: restoring division, one quotient bit
  // pair per stage (hue 6 bits, saturation 8 bits). Stage 10: finish.
  localparam int unsigned NSt = 9;

  logic [NSt:0]     v_q;
  cls_t             c_q  [NSt+1];
  logic [QuoW-1:0]  hr_q [NSt+1];
  logic [QuoW-1:0]  sr_q [NSt+1];
  logic [ChanW-1:0] hq_q [NSt+1];
  logic [ChanW-1:0] sq_q [NSt+1];
  logic             adv;
  logic [7:0]       hue_q, sat_q, lum_q;
  logic             mat_q, ov_q;

  assign adv = !ov_q || out_ready;
  assign cls_ready_o = adv;

  // One quotient bit: shift-subtract at bit position k.
  function automatic void div_bit(input logic [QuoW-1:0] rin, input logic [SumW-1:0] d,
                                  input int k, input logic [ChanW-1:0] qin,
                                  output logic [QuoW-1:0] rout, output logic [ChanW-1:0] qout);
    logic [QuoW+8:0] t;
    t = {{QuoW{1'b0}}, d} << k;
    rout = rin;
    qout = qin;
    if ({9'd0, rin} >= t) begin
      rout = rin - t[QuoW-1:0];
      qout[k] = 1'b1;
    end
  endfunction

  logic [QuoW-1:0]  hr_n [NSt+1];
  logic [QuoW-1:0]  sr_n [NSt+1];
  logic [ChanW-1:0] hq_n [NSt+1];
  logic [ChanW-1:0] sq_n [NSt+1];
  logic [QuoW-1:0]  ht, st;
  logic [ChanW-1:0] hqt, sqt;

  always_comb begin
    hr_n[0] = QuoW'(cls_i.hue_num) * QuoW'(40);
    sr_n[0] = QuoW'(cls_i.dif) * QuoW'(240);
    hq_n[0] = '0;
    sq_n[0] = '0;
    for (int s = 1; s <= NSt; s++) begin
      ht = hr_q[s-1];
      st = sr_q[s-1];
      hqt = hq_q[s-1];
      sqt = sq_q[s-1];
      if (s <= 8) begin
        div_bit(st, c_q[s-1].sat_den, 8 - s, sqt, st, sqt);
        if (s >= 3) div_bit(ht, {1'b0, c_q[s-1].dif}, 8 - s, hqt, ht, hqt);
      end
      hr_n[s] = ht;
      sr_n[s] = st;
      hq_n[s] = hqt;
      sq_n[s] = sqt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v_q <= {v_q[NSt-1:0], cls_valid_i};
      ov_q <= v_q[NSt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0] <= cls_i;
      hr_q[0] <= hr_n[0];
      sr_q[0] <= sr_n[0];
      hq_q[0] <= hq_n[0];
      sq_q[0] <= sq_n[0];
      for (int s = 1; s <= NSt; s++) begin
        c_q[s] <= c_q[s-1];
        hr_q[s] <= hr_n[s];
        sr_q[s] <= sr_n[s];
        hq_q[s] <= hq_n[s];
        sq_q[s] <= sq_n[s];
      end
    end
  end

  logic [ChanW-1:0] hue_f, sat_f;
  logic [9:0]       hsum;
  cls_t             cf;

  always_comb begin
    cf = c_q[NSt];
    // Truncation toward zero: the magnitude quotient carries the sign.
    case (cf.sector)
      SecRed:   hsum = cf.neg ? (10'd240 - {2'd0, hq_q[NSt]}) : {2'd0, hq_q[NSt]};
      SecGreen: hsum = cf.neg ? (10'd80 - {2'd0, hq_q[NSt]}) : (10'd80 + {2'd0, hq_q[NSt]});
      default:  hsum = cf.neg ? (10'd160 - {2'd0, hq_q[NSt]}) : (10'd160 + {2'd0, hq_q[NSt]});
    endcase
    if (cf.neg && !cf.wrap && cf.sector == SecRed) hsum = '0;
    hue_f = cf.grey ? '0 : ((hsum > 10'd240) ? FullScale : hsum[7:0]);
    sat_f = (cf.grey || cf.sat_zero) ? '0 :
            ((sq_q[NSt] > FullScale) ? FullScale : sq_q[NSt]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue_q <= hue_f;
      sat_q <= sat_f;
      lum_q <= cf.lum;
      mat_q <= (hue_f >= win_i.hue_low) && (hue_f <= win_i.hue_high) &&
               (sat_f >= win_i.sat_low) && (sat_f <= win_i.sat_high) &&
               (cf.lum >= win_i.lum_low) && (cf.lum <= win_i.lum_high);
    end
  end

  assign out_valid = ov_q;
  assign hue_o = hue_q;
  assign saturation_o = sat_q;
  assign luminance_o = lum_q;
  assign match_o = mat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> hue_o <= FullScale) else $error("hue out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> saturation_o <= FullScale) else $error("saturation out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

/* rtl/rgb_to_hsl_color_match.sv */
// Top level of the RGB to HSL converter with color window match.
`timescale 1ns / 1ps
// Usage: one pixel item (red_i, green_i, blue_i) enters on in_valid/in_ready,
// one result item (hue_o, saturation_o, luminance_o, match_o) leaves on
// out_valid/out_ready, in order. Hue, saturation and luminance are on a
// 0..240 scale; match_o is high when all three lie inside the configured
// inclusive windows. Windows are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must do so only while the block is idle, which the
// block does not enforce. Indexes above five are ignored. Throughput is one
// item per cycle while out_ready is high. Items pass the front stage, queue,
// back pipeline (numerator stage, division stages each giving one saturation
// and, in the later ones, one hue quotient bit, and a finish stage) and
// output register. Reset empties all stages and sets the windows to the full
// 0..240 range. When the receiver stalls, the back pipeline holds, the queue
// fills and then in_ready drops; nothing is lost or repeated.
module rgb_to_hsl_color_match #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] hue_o,
  output logic [7:0] saturation_o,
  output logic [7:0] luminance_o,
  output logic       match_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  import rhcm_pkg::*;

  win_t win_q;
  cls_t f_cls, q_cls;
  logic f_v, f_r, q_v, q_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '{hue_low: '0, hue_high: FullScale, sat_low: '0,
                 sat_high: FullScale, lum_low: '0, lum_high: FullScale};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHueLow:  win_q.hue_low <= cfg_data_i;
        CfgHueHigh: win_q.hue_high <= cfg_data_i;
        CfgSatLow:  win_q.sat_low <= cfg_data_i;
        CfgSatHigh: win_q.sat_high <= cfg_data_i;
        CfgLumLow:  win_q.lum_low <= cfg_data_i;
        CfgLumHigh: win_q.lum_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rhcm_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .red_i, .green_i, .blue_i,
    .cls_valid_o(f_v), .cls_ready_i(f_r), .cls_o(f_cls)
  );

  rhcm_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_v), .wr_ready_o(f_r), .wr_data_i(f_cls),
    .rd_valid_o(q_v), .rd_ready_i(q_r), .rd_data_o(q_cls)
  );

  rhcm_back u_back (
    .clk_i, .rst_ni, .cls_valid_i(q_v), .cls_ready_o(q_r), .cls_i(q_cls),
    .win_i(win_q), .out_valid, .out_ready, .hue_o, .saturation_o,
    .luminance_o, .match_o
  );

endmodule

/* test/rhcm_checker.sv */
// Checker that predicts HSL results and window matches and compares them with the block.
`timescale 1ns / 1ps
module rhcm_checker
  import rhcm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] hue_o,
  input  logic [7:0] saturation_o,
  input  logic [7:0] luminance_o,
  input  logic       match_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] lum;
    logic       match;
  } hsl_t;

  win_t win;
  hsl_t hsl_queue[$];

  function automatic int clamp240(int v);
    if (v < 0) return 0;
    if (v > 240) return 240;
    return v;
  endfunction

  function automatic hsl_t convert_pixel(int r, int g, int b, win_t w);
    int mx, mn, dif, sum, h, s, l;
    hsl_t res;
    mx = r; mn = r; h = 0; s = 0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dif = mx - mn;
    sum = mx + mn;
    l = sum * 240 / 255 / 2;
    if (dif != 0) begin
      if (mx == r) begin
        h = 40 * (g - b) / dif;
        if (g < b) h += 240;
      end else if (mx == g) begin
        h = 40 * (b - r) / dif + 80;
      end else begin
        h = 40 * (r - g) / dif + 160;
      end
      if (l == 0) s = 0;
      else if (l <= 120) s = dif * 240 / sum;
      else s = dif * 240 / (511 - sum);
    end
    res.hue = 8'(clamp240(h));
    res.sat = 8'(clamp240(s));
    res.lum = 8'(clamp240(l));
    res.match = res.hue >= w.hue_low && res.hue <= w.hue_high &&
                res.sat >= w.sat_low && res.sat <= w.sat_high &&
                res.lum >= w.lum_low && res.lum <= w.lum_high;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("Mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hsl_t want;
    if (!rst_ni) begin
      win <= '{8'd0, 8'd240, 8'd0, 8'd240, 8'd0, 8'd240};
      hsl_queue.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHueLow: win.hue_low <= cfg_data_i;
          CfgHueHigh: win.hue_high <= cfg_data_i;
          CfgSatLow: win.sat_low <= cfg_data_i;
          CfgSatHigh: win.sat_high <= cfg_data_i;
          CfgLumLow: win.lum_low <= cfg_data_i;
          CfgLumHigh: win.lum_high <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (hsl_queue.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          want = hsl_queue.pop_front();
          if (hue_o !== want.hue) report("hue", hue_o, want.hue);
          if (saturation_o !== want.sat) report("saturation", saturation_o, want.sat);
          if (luminance_o !== want.lum) report("luminance", luminance_o, want.lum);
          if (match_o !== want.match) report("match", match_o, want.match);
        end
      end
      if (in_valid && in_ready)
        hsl_queue.push_back(convert_pixel(int'(red_i), int'(green_i), int'(blue_i), win));
      pending_o = hsl_queue.size();
    end
  end

endmodule

/* test/tb.sv */
// Testbench top that drives pixels and window settings and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import rhcm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_we_i = 1'b0;
  logic [7:0] red_i = '0, green_i = '0, blue_i = '0, cfg_data_i = '0;
  logic [2:0] cfg_idx_i = '0;
  logic in_ready, out_valid, match_o;
  logic [7:0] hue_o, saturation_o, luminance_o;
  int fail_count, pending;
  int out_wait;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  rgb_to_hsl_color_match dut (.*);

  rhcm_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    int w;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else if (out_valid && out_ready) begin
      w = ($urandom_range(0, 1) == 1) ? 0 : int'($urandom_range(0, 13));
      out_wait <= w;
      out_ready <= (w == 0);
    end else if (out_wait != 0) begin
      out_wait <= out_wait - 1;
      out_ready <= (out_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain_queue();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_window(logic [2:0] idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic run_random(int count);
    bit idle;
    for (int i = 0; i < count; i++) begin
      idle = ($urandom_range(0, 1) == 1);
      case ($urandom_range(0, 4))
        0: send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), idle);
        1: begin
          logic [7:0] v;
          v = 8'($urandom_range(0, 255));
          send_pixel(v, v, 8'($urandom_range(0, 255)), idle);
        end
        2: begin
          logic [7:0] v;
          v = 8'($urandom_range(0, 3));
          send_pixel(v, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), idle);
        end
        3: begin
          logic [7:0] v;
          v = 8'($urandom_range(250, 255));
          send_pixel(v, 8'($urandom_range(240, 255)), 8'($urandom_range(240, 255)), idle);
        end
        default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), idle);
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd10, 1'b0);
    send_pixel(8'd200, 8'd200, 8'd10, 1'b0);
    send_pixel(8'd10, 8'd200, 8'd200, 1'b0);
    send_pixel(8'd200, 8'd10, 8'd200, 1'b0);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd2, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd255, 1'b0);
    send_pixel(8'd170, 8'd85, 8'd85, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd85, 8'd170, 8'd85, 1'b0);
    run_random(150);
    drain_queue();
    for (int phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < 6; k++) begin
        logic [7:0] val;
        case (phase)
          0: val = (k % 2 == 0) ? 8'd0 : 8'd240;
          1: val = (k % 2 == 0) ? 8'd255 : 8'd255;
          2: val = (k % 2 == 0) ? 8'd200 : 8'd50;
          3: val = (k % 2 == 0) ? 8'd240 : 8'd0;
          default: val = (k % 2 == 0) ? 8'($urandom_range(0, 120)) :
                                        8'($urandom_range(120, 240));
        endcase
        write_window(3'(k), val);
      end
      write_window(3'd6, 8'($urandom));
      write_window(3'd7, 8'($urandom));
      cfg_we_i <= 1'b0;
      run_random(160);
      drain_queue();
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
